FILE: design/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants for the display init table parser
// Holds the parse phase encoding, result kinds and delay code constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 9;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_CMD    = 3'd1,
    PH_HEADER = 3'd2,
    PH_ARGS   = 3'd3,
    PH_DELAY  = 3'd4
  } phase_t;

  localparam kind_t KIND_CMD   = 2'd0;
  localparam kind_t KIND_DATA  = 2'd1;
  localparam kind_t KIND_DELAY = 2'd2;
  localparam kind_t KIND_EMPTY = 2'd3;

  localparam byte_t  DELAY_CODE_LONG = 8'hFF;
  localparam value_t DELAY_LONG_MS   = 9'd500;
  localparam byte_t  MASK_RESET      = 8'h80;

endpackage

`default_nettype wire

FILE: design/dtp_if.sv
// ----------------------------------------------------------------------------
// dtp_byte_if / dtp_result_if: valid/ready channels of the table parser
// One carries table bytes in, the other carries parsed result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtp_byte_if;
  logic             valid;
  logic             ready;
  dtp_pkg::byte_t   table_byte;

  modport source (output valid, output table_byte, input ready);
  modport sink   (input valid, input table_byte, output ready);
endinterface

interface dtp_result_if;
  logic             valid;
  logic             ready;
  dtp_pkg::kind_t   kind;
  dtp_pkg::value_t  value;
  logic             table_end;

  modport source (output valid, output kind, output value, output table_end, input ready);
  modport sink   (input valid, input kind, input value, input table_end, output ready);
endinterface

`default_nettype wire

FILE: design/display_init_table_parser.sv
// ----------------------------------------------------------------------------
// display_init_table_parser: panel start-up command table parser
// Decodes table bytes into command, data and delay request beats.
// ----------------------------------------------------------------------------
// Usage:
//   table_bytes: one table byte per beat (valid/ready). The first byte of a
//     table is the command count, then per command a command byte, a header
//     byte, the argument bytes and an optional delay byte.
//   results: kind, value and table_end per beat. The command write leaves on
//     the header byte; count and command bytes give no beat. A zero count
//     gives a single empty-table beat.
//   cfg_we/cfg_data: write delay_flag_mask while the parser is idle.
// An accepted byte's result beat is in the output register in the cycle
// after. Throughput is one byte per cycle unless the receiver stalls: the
// phase decode is a single level of logic between the state registers
// and the output register. table_bytes.ready stays high while the output
// register is empty or being drained, so a stalled receiver holds the
// parser after one pending beat. Reset returns to the count phase,
// empties the output register and sets the mask to 0x80.
// ----------------------------------------------------------------------------
`default_nettype none

module display_init_table_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire dtp_pkg::byte_t  cfg_data,
  dtp_byte_if.sink             table_bytes,
  dtp_result_if.source         results
);
  import dtp_pkg::*;

  byte_t  delay_flag_mask;
  phase_t phase, phase_next;
  byte_t  commands_left, commands_left_next;
  byte_t  args_left, args_left_next;
  logic   delay_pending, delay_pending_next;
  byte_t  cmd_hold, cmd_hold_next;

  logic   res_valid;
  kind_t  res_kind;
  value_t res_value;
  logic   res_end;

  logic   out_valid;
  kind_t  out_kind;
  value_t out_value;
  logic   out_end;

  logic   accept;
  byte_t  b;

  assign b                 = table_bytes.table_byte;
  assign table_bytes.ready = !out_valid || results.ready;
  assign accept            = table_bytes.valid && table_bytes.ready;

  // Next state
  always_comb begin
    byte_t al;
    logic  dp;
    byte_t cl_dec;
    phase_next         = phase;
    commands_left_next = commands_left;
    args_left_next     = args_left;
    delay_pending_next = delay_pending;
    cmd_hold_next      = cmd_hold;
    cl_dec             = commands_left - 8'd1;
    al                 = args_left;
    dp                 = delay_pending;
    case (phase)
      PH_CMD: begin
        cmd_hold_next = b;
        phase_next    = PH_HEADER;
      end
      PH_HEADER, PH_ARGS: begin
        if (phase == PH_HEADER) begin
          dp = (b & delay_flag_mask) != '0;
          al = b & ~delay_flag_mask;
        end else begin
          al = args_left - 8'd1;
        end
        args_left_next     = al;
        delay_pending_next = dp;
        if (al != '0) begin
          phase_next = PH_ARGS;
        end else if (dp) begin
          phase_next = PH_DELAY;
        end else begin
          commands_left_next = cl_dec;
          phase_next         = (cl_dec == '0) ? PH_COUNT : PH_CMD;
        end
      end
      PH_DELAY: begin
        delay_pending_next = 1'b0;
        commands_left_next = cl_dec;
        phase_next         = (cl_dec == '0) ? PH_COUNT : PH_CMD;
      end
      default: begin
        if (b == '0) begin
          phase_next = PH_COUNT;
        end else begin
          commands_left_next = b;
          args_left_next     = '0;
          delay_pending_next = 1'b0;
          phase_next         = PH_CMD;
        end
      end
    endcase
  end

  // Result beat for the byte on the input; the table ends when we fall
  // back to the count phase.
  always_comb begin
    res_valid = 1'b1;
    res_kind  = KIND_EMPTY;
    res_value = '0;
    res_end   = (phase_next == PH_COUNT);
    case (phase)
      PH_CMD: begin
        res_valid = 1'b0;
      end
      PH_HEADER: begin
        res_kind  = KIND_CMD;
        res_value = {1'b0, cmd_hold};
      end
      PH_ARGS: begin
        res_kind  = KIND_DATA;
        res_value = {1'b0, b};
      end
      PH_DELAY: begin
        res_kind  = KIND_DELAY;
        res_value = (b == DELAY_CODE_LONG) ? DELAY_LONG_MS : {1'b0, b};
      end
      default: begin
        res_valid = (b == '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_flag_mask <= MASK_RESET;
      phase           <= PH_COUNT;
      commands_left   <= '0;
      args_left       <= '0;
      delay_pending   <= 1'b0;
      cmd_hold        <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_flag_mask <= cfg_data;
      end
      if (accept) begin
        phase         <= phase_next;
        commands_left <= commands_left_next;
        args_left     <= args_left_next;
        delay_pending <= delay_pending_next;
        cmd_hold      <= cmd_hold_next;
        out_valid     <= res_valid;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: load only on a byte that makes a beat
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind  <= res_kind;
      out_value <= res_value;
      out_end   <= res_end;
    end
  end

  assign results.valid     = out_valid;
  assign results.kind      = out_kind;
  assign results.value     = out_value;
  assign results.table_end = out_end;

endmodule

`default_nettype wire
